// ===== rtl/core/lcgss_pkg.sv =====
// shared types, constants and helper functions for the lcg seed search core
// no dependencies; used by every other file of the core but lcgss_req_if
package lcgss_pkg;

  // longest target sequence that can be matched
  localparam int MAX_SEQUENCE = 16;
  localparam int SEQ_IDX_W    = $clog2(MAX_SEQUENCE);

  // field widths
  localparam int SEED_W       = 32;
  localparam int LEN_W        = 5;
  localparam int TGT_W        = 5;
  localparam int TGT_WORD_W   = 40;
  localparam int TGT_ALL_W    = 2 * TGT_WORD_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 40;

  // lcg constants
  localparam logic [SEED_W-1:0] LCG_MUL    = 32'd214013;
  localparam logic [SEED_W-1:0] LCG_ADD    = 32'd2531011;
  localparam logic [SEED_W-1:0] RESET_SEED = 32'd1;

  // reset values of the registers
  localparam logic [LEN_W-1:0] RESET_SEQ_LEN = 5'd9;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_SEED     = 3'd0,
    REG_SEQ_LEN        = 3'd1,
    REG_TARGETS_FIRST  = 3'd2,
    REG_TARGETS_SECOND = 3'd3,
    REG_STOP_AT_FIRST  = 3'd4
  } reg_idx_t;

  // queued command
  typedef struct packed {
    logic restart;
  } cmd_t;

  // register set seen by the back end
  typedef struct packed {
    logic [SEED_W-1:0]    start_seed;
    logic [LEN_W-1:0]     sequence_length;
    logic [TGT_ALL_W-1:0] targets;
    logic                 stop_at_first;
  } cfg_t;

  // one step of the generator, modulo 2^32
  function automatic logic [SEED_W-1:0] lcg_next(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] p;
    p = x * LCG_MUL;
    return p + LCG_ADD;
  endfunction

  // (25 * (x >> 16)) >> 16, built from shifts and adds
  function automatic logic [TGT_W-1:0] scaled_out(input logic [SEED_W-1:0] x);
    logic [20:0] hi;
    logic [20:0] s;
    hi = {5'd0, x[31:16]};
    s  = (hi << 4) + (hi << 3) + hi;
    return s[20:16];
  endfunction

  // target k out of the packed pair of target words
  function automatic logic [TGT_W-1:0] target_at(input logic [TGT_ALL_W-1:0] t,
                                                 input logic [SEQ_IDX_W-1:0] k);
    return t[int'(k) * TGT_W +: TGT_W];
  endfunction

  // index of the last compared target, length clamped to 1..MAX_SEQUENCE
  function automatic logic [SEQ_IDX_W-1:0] last_index(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len > LEN_W'(MAX_SEQUENCE)) begin
      m = LEN_W'(MAX_SEQUENCE - 1);
    end else begin
      m = len - 1'b1;
    end
    return m[SEQ_IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lcgss_req_if.sv =====
// request channel of the lcg seed search core: one word per tick
// depends on nothing
interface lcgss_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ===== rtl/core/lcgss_rsp_if.sv =====
// result channel of the lcg seed search core
// depends on lcgss_pkg for field widths
interface lcgss_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          matched;
  logic [lcgss_pkg::SEED_W-1:0]  match_start;
  logic [lcgss_pkg::SEED_W-1:0]  match_end;
  logic [lcgss_pkg::SEED_W-1:0]  scan_index;
  logic                          halted;

  modport source (output valid, output matched, output match_start, output match_end,
                  output scan_index, output halted, input ready);
  modport sink   (input valid, input matched, input match_start, input match_end,
                  input scan_index, input halted, output ready);
endinterface

// ===== rtl/core/lcgss_cfg_if.sv =====
// register write channel of the lcg seed search core
// depends on lcgss_pkg for index and data widths
interface lcgss_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lcgss_pkg::CFG_IDX_W-1:0]  index;
  logic [lcgss_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/lcg_sequence_seed_search_core.sv =====
// lcg seed search core: ticks in order; a request word is queued, then the back end runs
// a reload step on restart, a start step, the compare loop and a finish step
// one tick is in the back end at a time: a new command waits until the last is done; the
// compare loop alternates compare and advance states through the shared 32x32 multiply-add
// synchronous reset restores the config registers to their defaults and the scan to start
// seed 1; the result register is empty after reset and no clearing pass is needed
module lcg_sequence_seed_search_core (
  input  logic        clk,
  input  logic        rst,
  lcgss_req_if.sink   req,
  lcgss_rsp_if.source rsp,
  lcgss_cfg_if.sink   cfg
);

  logic [lcgss_pkg::SEED_W-1:0]     start_seed;
  logic [lcgss_pkg::LEN_W-1:0]      sequence_length;
  logic [lcgss_pkg::TGT_WORD_W-1:0] targets_first;
  logic [lcgss_pkg::TGT_WORD_W-1:0] targets_second;
  logic                             stop_at_first;

  lcgss_pkg::cfg_t cfg_regs;
  lcgss_pkg::cmd_t q_cmd;
  logic            q_valid;
  logic            pop;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      start_seed      <= lcgss_pkg::RESET_SEED;
      sequence_length <= lcgss_pkg::RESET_SEQ_LEN;
      targets_first   <= '0;
      targets_second  <= '0;
      stop_at_first   <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (lcgss_pkg::reg_idx_t'(cfg.index))
        lcgss_pkg::REG_START_SEED:     start_seed      <= cfg.data[lcgss_pkg::SEED_W-1:0];
        lcgss_pkg::REG_SEQ_LEN:        sequence_length <= cfg.data[lcgss_pkg::LEN_W-1:0];
        lcgss_pkg::REG_TARGETS_FIRST:  targets_first   <= cfg.data[lcgss_pkg::TGT_WORD_W-1:0];
        lcgss_pkg::REG_TARGETS_SECOND: targets_second  <= cfg.data[lcgss_pkg::TGT_WORD_W-1:0];
        lcgss_pkg::REG_STOP_AT_FIRST:  stop_at_first   <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // register set handed to the back end
  assign cfg_regs.start_seed      = start_seed;
  assign cfg_regs.sequence_length = sequence_length;
  assign cfg_regs.targets         = {targets_second, targets_first};
  assign cfg_regs.stop_at_first   = stop_at_first;

  // request intake and command queue
  lcgss_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .pop     (pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  // candidate evaluation and result register
  lcgss_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .cfg_regs (cfg_regs),
    .rsp      (rsp)
  );

endmodule

// ===== rtl/core/lcgss_front.sv =====
// front end: accepts request words and queues them as commands
// depends on lcgss_pkg and lcgss_req_if
module lcgss_front (
  input  logic                clk,
  input  logic                rst,
  lcgss_req_if.sink           req,
  input  logic                pop,
  output logic                q_valid,
  output lcgss_pkg::cmd_t     q_cmd
);

  lcgss_pkg::cmd_t                    q_mem [lcgss_pkg::QUEUE_DEPTH];
  logic [lcgss_pkg::Q_PTR_W-1:0]      wr_ptr;
  logic [lcgss_pkg::Q_PTR_W-1:0]      rd_ptr;
  logic [lcgss_pkg::Q_CNT_W-1:0]      count;
  logic                               push;
  logic                               take;

  // handshake and queue status
  assign req.ready = (count != lcgss_pkg::Q_CNT_W'(lcgss_pkg::QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != '0);
  assign take      = pop && q_valid;
  assign q_cmd     = q_mem[rd_ptr];

  // pointer advance with wrap at the queue depth
  function automatic logic [lcgss_pkg::Q_PTR_W-1:0] ptr_inc(
      input logic [lcgss_pkg::Q_PTR_W-1:0] p);
    if (p == lcgss_pkg::Q_PTR_W'(lcgss_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr].restart <= req.restart;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (take) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/lcgss_back.sv =====
// back end: runs one candidate seed per command and drives the result register
// depends on lcgss_pkg and lcgss_rsp_if
module lcgss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  lcgss_pkg::cmd_t     q_cmd,
  output logic                pop,
  input  lcgss_pkg::cfg_t     cfg_regs,
  lcgss_rsp_if.source         rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RELOAD,
    S_START,
    S_CMP,
    S_ADV,
    S_FINISH
  } state_t;

  state_t                              state;
  logic [lcgss_pkg::SEED_W-1:0]        candidate;
  logic [lcgss_pkg::SEED_W-1:0]        preceding;
  logic [lcgss_pkg::SEED_W-1:0]        tick_count;
  logic                                scan_stopped;
  logic [lcgss_pkg::SEED_W-1:0]        walk;
  logic [lcgss_pkg::SEQ_IDX_W-1:0]     k;
  logic                                hit;
  logic                                idle_tick;

  logic [lcgss_pkg::SEED_W-1:0]        adv_in;
  logic [lcgss_pkg::SEED_W-1:0]        adv_out;
  logic [lcgss_pkg::SEQ_IDX_W-1:0]     k_last;
  logic                                tgt_ok;
  logic                                slot_free;
  logic [lcgss_pkg::SEED_W-1:0]        tick_next;
  logic                                stop_next;

  // shared advance unit, one multiply-add
  always_comb begin
    case (state)
      S_RELOAD: adv_in = cfg_regs.start_seed;
      S_FINISH: adv_in = candidate;
      default:  adv_in = walk;
    endcase
  end
  assign adv_out = lcgss_pkg::lcg_next(adv_in);

  // compare of the current walk seed against target k
  assign k_last = lcgss_pkg::last_index(cfg_regs.sequence_length);
  assign tgt_ok = (lcgss_pkg::scaled_out(walk) ==
                   lcgss_pkg::target_at(cfg_regs.targets, k));

  // end-of-tick bookkeeping
  assign tick_next = tick_count + 1'b1;
  assign stop_next = (hit && cfg_regs.stop_at_first) || (tick_next == '1);
  assign slot_free = !rsp.valid || rsp.ready;
  assign pop       = (state == S_IDLE) && q_valid;

  // sequencer, scan state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      preceding    <= lcgss_pkg::RESET_SEED;
      candidate    <= lcgss_pkg::lcg_next(lcgss_pkg::RESET_SEED);
      tick_count   <= '0;
      scan_stopped <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      // result word leaves when taken, unless the finish step loads the next one
      if (rsp.valid && rsp.ready && state != S_FINISH) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= q_cmd.restart ? S_RELOAD : S_START;
          end
        end
        S_RELOAD: begin
          preceding    <= cfg_regs.start_seed;
          candidate    <= adv_out;
          tick_count   <= '0;
          scan_stopped <= 1'b0;
          state        <= S_START;
        end
        S_START: begin
          walk      <= candidate;
          k         <= '0;
          hit       <= 1'b0;
          idle_tick <= scan_stopped;
          state     <= scan_stopped ? S_FINISH : S_CMP;
        end
        S_CMP: begin
          if (!tgt_ok) begin
            hit   <= 1'b0;
            state <= S_FINISH;
          end else if (k == k_last) begin
            // end seed is one advance past the last compared seed
            hit   <= 1'b1;
            walk  <= adv_out;
            state <= S_FINISH;
          end else begin
            k     <= k + 1'b1;
            walk  <= adv_out;
            state <= S_ADV;
          end
        end
        S_ADV: begin
          walk  <= adv_out;
          state <= S_CMP;
        end
        S_FINISH: begin
          if (slot_free) begin
            rsp.valid       <= 1'b1;
            rsp.matched     <= hit;
            rsp.match_start <= hit ? preceding : '0;
            rsp.match_end   <= hit ? walk : '0;
            rsp.scan_index  <= tick_count;
            if (idle_tick) begin
              rsp.halted <= 1'b1;
            end else begin
              rsp.halted   <= stop_next;
              scan_stopped <= stop_next;
              if (!(hit && cfg_regs.stop_at_first)) begin
                preceding  <= candidate;
                candidate  <= adv_out;
                tick_count <= tick_next;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // only a restart may resume a stopped scan
  a_stop_cleared_by_reload: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(scan_stopped)) |-> $past(state == S_RELOAD))
    else $error("scan resumed without a restart");

  // a saturated tick count always leaves the scan stopped
  a_tick_saturation: assert property (@(posedge clk) disable iff (rst)
    (tick_count == '1) |-> scan_stopped)
    else $error("tick count saturated while scan still running");

  // results are only loaded from the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(rsp.valid)) |-> $past(state == S_FINISH))
    else $error("result word loaded outside the finish step");

  // a command is taken only while no result is being built
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_START || state == S_RELOAD))
    else $error("command taken without starting a tick");
`endif

endmodule
